// ===== design/gcode_line_parser_defines.svh =====
// assertion macros for the gcode line parser
// no dependencies
`ifndef GCODE_LINE_PARSER_DEFINES_SVH
`define GCODE_LINE_PARSER_DEFINES_SVH
`ifndef ASSERT_OFF
`define GLP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define GLP_NEVER(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("forbidden condition");
`else
`define GLP_ASSERT(lbl, prop)
`define GLP_NEVER(lbl, prop)
`endif
`endif

// ===== design/glp_pkg.sv =====
// types, constants and helpers for the gcode line parser
// no dependencies
`default_nettype none
package glp_pkg;
  localparam int FRAC_DIGITS = 4;
  localparam int VW = 32;
  localparam int FCW = 3;
  localparam int QDEPTH = 2;
  localparam int QAW = 1;
  localparam int QCW = 2;
  localparam longint unsigned CAP_L = 64'd1 << (VW - 1);
  localparam longint unsigned P_L = 64'd10 ** FRAC_DIGITS;
  localparam logic [VW-1:0] CAP = VW'(CAP_L);
  localparam logic [VW-1:0] CAP_M1 = VW'(CAP_L - 64'd1);
  localparam logic [VW-1:0] CAP_DIV10 = VW'(CAP_L / 64'd10);
  localparam logic [VW-1:0] SCALE = VW'(P_L);
  localparam logic [15:0] TOOL_LIM = 16'((CAP_L / P_L < 64'd32768) ? CAP_L / P_L : 64'd32768);
  localparam logic [15:0] TOOL_POS_MAX = 16'd32767;

  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_SEMI = 8'h3b;
  localparam logic [7:0] CH_LPAR = 8'h28;
  localparam logic [7:0] CH_RPAR = 8'h29;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT = 8'h2e;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_X = 8'h58;
  localparam logic [7:0] CH_Y = 8'h59;
  localparam logic [7:0] CH_Z = 8'h5a;
  localparam logic [7:0] CH_I = 8'h49;
  localparam logic [7:0] CH_J = 8'h4a;
  localparam logic [7:0] CH_K = 8'h4b;
  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_M = 8'h4d;
  localparam logic [VW-1:0] M_TOOL_CHANGE = VW'(6);

  localparam logic [2:0] MK_RAPID = 3'd0;
  localparam logic [2:0] MK_TOOL = 3'd4;

  typedef enum logic [1:0] {PH_START, PH_TEXT, PH_SKIP, PH_SEMI} line_phase_e;
  typedef enum logic [2:0] {TK_NONE, TK_LETTER, TK_SIGN, TK_INT, TK_FRAC, TK_TAIL} tok_phase_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } in_t;

  typedef struct packed {
    logic [2:0]           motion_kind;
    logic signed [VW-1:0] pos_x;
    logic signed [VW-1:0] pos_y;
    logic signed [VW-1:0] pos_z;
    logic signed [VW-1:0] center_i;
    logic signed [VW-1:0] center_j;
    logic signed [VW-1:0] center_k;
    logic signed [VW-1:0] feed_value;
    logic signed [15:0]   tool_number;
  } out_t;

  typedef struct packed {
    logic          tok;
    logic [7:0]    letter;
    logic          neg;
    logic [VW-1:0] acc;
    logic [15:0]   whole;
    logic          lend;
    logic          allow;
  } event_t;

  typedef struct packed {
    logic [QCW-1:0] count;
    logic           full;
    logic           empty;
  } q_status_t;

  function automatic logic [VW-1:0] pow10(input logic [FCW-1:0] n);
    logic [VW-1:0] r;
    case (n)
      3'd0: r = VW'(1);
      3'd1: r = VW'(10);
      3'd2: r = VW'(100);
      3'd3: r = VW'(1000);
      3'd4: r = VW'(10000);
      3'd5: r = VW'(100000);
      3'd6: r = VW'(1000000);
      default: r = VW'(1);
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== design/gcode_line_parser.sv =====
// top level of the gcode line parser: front end, event queue, back end
// depends on glp_pkg, glp_front, glp_fifo, glp_back, gcode_line_parser_defines.svh
//
// channel | signals                           | payload
// text in | in_valid_i / in_ready_o           | in_data_i  (glp_pkg::in_t)
// command | out_valid_o / out_ready_i         | out_data_o (glp_pkg::out_t)
//
// one text byte per cycle while the queue is not full; a line-ending beat passes the
// queue, then its command waits in the output register; the front end is a byte
// scanner; the back end retires one event per cycle while its output register is
// free or being read; a two-entry queue decouples them; in_ready_o drops only while
// the queue is full; reset is asynchronous and needs no clearing pass
`default_nettype none
`include "gcode_line_parser_defines.svh"
module gcode_line_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  glp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output glp_pkg::out_t out_data_o
);
  logic               acc, push, pop;
  glp_pkg::event_t    ev_in, ev_out;
  glp_pkg::q_status_t qs;

  assign in_ready_o = !qs.full;
  assign acc = in_valid_i && in_ready_o;

  glp_front u_front (
    .clk_i, .rst_ni, .acc_i(acc), .data_i(in_data_i), .push_o(push), .ev_o(ev_in)
  );

  glp_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(ev_in), .pop_i(pop),
    .data_o(ev_out), .stat_o(qs)
  );

  glp_back u_back (
    .clk_i, .rst_ni, .ev_valid_i(!qs.empty), .ev_i(ev_out), .pop_o(pop),
    .out_valid_o, .out_ready_i, .out_data_o
  );

  `GLP_NEVER(a_q_over, qs.count > glp_pkg::QCW'(glp_pkg::QDEPTH))
  `GLP_NEVER(a_pop_empty, pop && qs.empty)
  `GLP_ASSERT(a_kind_range, out_valid_o |-> out_data_o.motion_kind <= glp_pkg::MK_TOOL)
  `GLP_ASSERT(a_ready_full, in_ready_o == (qs.count != glp_pkg::QCW'(glp_pkg::QDEPTH)))
endmodule
`default_nettype wire

// ===== design/glp_front.sv =====
// front end: line filter, comment stripping, tokenizer and number scan
// depends on glp_pkg
`default_nettype none
module glp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            acc_i,
  input  glp_pkg::in_t    data_i,
  output logic            push_o,
  output glp_pkg::event_t ev_o
);
  glp_pkg::line_phase_e phase_q, phase_d;
  glp_pkg::tok_phase_e  tok_q, tok_d;
  logic                 com_q, com_d;
  logic [7:0]           letter_q, letter_d;
  logic                 neg_q, neg_d;
  logic [glp_pkg::VW-1:0] acc_q, acc_d;
  logic [glp_pkg::FCW-1:0] fc_q, fc_d;
  logic                 dig_q, dig_d;
  logic [15:0]          whole_q, whole_d;
  logic [7:0]           c;
  logic                 is_ws, is_dig, fin, lend, allow;
  logic [3:0]           dv;
  logic [glp_pkg::VW:0] t;
  logic [19:0]          wt;

  always_comb begin
    c = data_i.text_byte;
    is_ws = (c == glp_pkg::CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    is_dig = (c >= 8'h30) && (c <= 8'h39);
    dv = 4'(c - 8'h30);
    phase_d = phase_q;
    tok_d = tok_q;
    com_d = com_q;
    letter_d = letter_q;
    neg_d = neg_q;
    acc_d = acc_q;
    fc_d = fc_q;
    dig_d = dig_q;
    whole_d = whole_q;
    fin = 1'b0;
    t = '0;
    wt = '0;
    if (c != glp_pkg::CH_LF) begin
      if (phase_d == glp_pkg::PH_START) begin
        phase_d = (c == glp_pkg::CH_SLASH) ? glp_pkg::PH_SKIP : glp_pkg::PH_TEXT;
      end
      if (phase_d == glp_pkg::PH_TEXT) begin
        if (c == glp_pkg::CH_SEMI) begin
          fin = (tok_q != glp_pkg::TK_NONE);
          tok_d = glp_pkg::TK_NONE;
          phase_d = glp_pkg::PH_SEMI;
          com_d = 1'b0;
        end else if (c == glp_pkg::CH_LPAR) begin
          com_d = 1'b1;
        end else if (c == glp_pkg::CH_RPAR) begin
          com_d = 1'b0;
        end else if (!com_q) begin
          if (is_ws) begin
            fin = (tok_q != glp_pkg::TK_NONE);
            tok_d = glp_pkg::TK_NONE;
          end else begin
            case (tok_q)
              glp_pkg::TK_NONE: begin
                letter_d = (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
                neg_d = 1'b0;
                acc_d = '0;
                fc_d = '0;
                dig_d = 1'b0;
                whole_d = '0;
                tok_d = glp_pkg::TK_LETTER;
              end
              glp_pkg::TK_LETTER, glp_pkg::TK_SIGN, glp_pkg::TK_INT: begin
                if (tok_q == glp_pkg::TK_LETTER &&
                    (c == glp_pkg::CH_PLUS || c == glp_pkg::CH_MINUS)) begin
                  neg_d = (c == glp_pkg::CH_MINUS);
                  tok_d = glp_pkg::TK_SIGN;
                end else if (is_dig) begin
                  tok_d = glp_pkg::TK_INT;
                  dig_d = 1'b1;
                  if (acc_q > glp_pkg::CAP_DIV10) begin
                    acc_d = glp_pkg::CAP;
                  end else begin
                    t = ({1'b0, acc_q} << 3) + ({1'b0, acc_q} << 1)
                        + ((glp_pkg::VW+1)'(dv) * {1'b0, glp_pkg::SCALE});
                    acc_d = (t > {1'b0, glp_pkg::CAP}) ? glp_pkg::CAP : t[glp_pkg::VW-1:0];
                  end
                  wt = ({4'd0, whole_q} << 3) + ({4'd0, whole_q} << 1) + 20'(dv);
                  whole_d = (wt > {4'd0, glp_pkg::TOOL_LIM}) ? glp_pkg::TOOL_LIM : wt[15:0];
                end else if (c == glp_pkg::CH_DOT) begin
                  tok_d = glp_pkg::TK_FRAC;
                end else begin
                  tok_d = glp_pkg::TK_TAIL;
                end
              end
              glp_pkg::TK_FRAC: begin
                if (is_dig) begin
                  dig_d = 1'b1;
                  if (fc_q < glp_pkg::FCW'(glp_pkg::FRAC_DIGITS)) begin
                    t = {1'b0, acc_q} + ((glp_pkg::VW+1)'(dv) *
                        {1'b0, glp_pkg::pow10(glp_pkg::FCW'(glp_pkg::FRAC_DIGITS - 1) - fc_q)});
                    acc_d = (t > {1'b0, glp_pkg::CAP}) ? glp_pkg::CAP : t[glp_pkg::VW-1:0];
                    fc_d = fc_q + 1'b1;
                  end
                end else begin
                  tok_d = glp_pkg::TK_TAIL;
                end
              end
              default: ;
            endcase
          end
        end
      end
    end
    lend = (c == glp_pkg::CH_LF) || data_i.text_end;
    allow = 1'b0;
    if (lend) begin
      if (phase_d == glp_pkg::PH_TEXT && tok_d != glp_pkg::TK_NONE) fin = 1'b1;
      allow = (phase_d == glp_pkg::PH_TEXT) || (phase_d == glp_pkg::PH_SEMI);
      phase_d = glp_pkg::PH_START;
      com_d = 1'b0;
      tok_d = glp_pkg::TK_NONE;
    end
    ev_o.tok = fin && dig_d;
    ev_o.letter = letter_d;
    ev_o.neg = neg_d;
    ev_o.acc = acc_d;
    ev_o.whole = whole_d;
    ev_o.lend = lend;
    ev_o.allow = allow;
    push_o = acc_i && (ev_o.tok || lend);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= glp_pkg::PH_START;
      tok_q <= glp_pkg::TK_NONE;
      com_q <= 1'b0;
      letter_q <= '0;
      neg_q <= 1'b0;
      acc_q <= '0;
      fc_q <= '0;
      dig_q <= 1'b0;
      whole_q <= '0;
    end else if (acc_i) begin
      phase_q <= phase_d;
      tok_q <= tok_d;
      com_q <= com_d;
      letter_q <= letter_d;
      neg_q <= neg_d;
      acc_q <= acc_d;
      fc_q <= fc_d;
      dig_q <= dig_d;
      whole_q <= whole_d;
    end
  end
endmodule
`default_nettype wire

// ===== design/glp_fifo.sv =====
// two-entry event queue between front and back end
// depends on glp_pkg
`default_nettype none
module glp_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  glp_pkg::event_t   data_i,
  input  logic              pop_i,
  output glp_pkg::event_t   data_o,
  output glp_pkg::q_status_t stat_o
);
  glp_pkg::event_t mem_q [glp_pkg::QDEPTH];
  logic [glp_pkg::QAW-1:0] wp_q, rp_q;
  logic [glp_pkg::QCW-1:0] cnt_q;

  always_comb begin
    stat_o.count = cnt_q;
    stat_o.full = (cnt_q == glp_pkg::QCW'(glp_pkg::QDEPTH));
    stat_o.empty = (cnt_q == '0);
    data_o = mem_q[rp_q];
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + glp_pkg::QCW'(push_i) - glp_pkg::QCW'(pop_i);
    end
  end
endmodule
`default_nettype wire

// ===== design/glp_back.sv =====
// back end: applies words to machine state and builds at most one command per line
// depends on glp_pkg
`default_nettype none
module glp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            ev_valid_i,
  input  glp_pkg::event_t ev_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output glp_pkg::out_t   out_data_o
);
  logic [1:0]             modal_q, modal_n;
  logic [2:0]             kind_q, kind_n;
  logic [glp_pkg::VW-1:0] ax_q [3];
  logic [glp_pkg::VW-1:0] ax_n [3];
  logic [glp_pkg::VW-1:0] arc_q [3];
  logic [glp_pkg::VW-1:0] arc_n [3];
  logic [glp_pkg::VW-1:0] feed_q, feed_n, v;
  logic [15:0]            tool_q, tool_n;
  logic [3:0]             flg_q, flg_n;
  logic                   ov_q, fire;
  glp_pkg::out_t          od_q;

  always_comb begin
    pop_o = ev_valid_i && (!ov_q || out_ready_i);
    if (ev_i.neg) v = '0 - ev_i.acc;
    else v = (ev_i.acc > glp_pkg::CAP_M1) ? glp_pkg::CAP_M1 : ev_i.acc;
    modal_n = modal_q;
    kind_n = kind_q;
    ax_n = ax_q;
    arc_n = arc_q;
    feed_n = feed_q;
    tool_n = tool_q;
    flg_n = flg_q;
    if (ev_i.tok) begin
      case (ev_i.letter)
        glp_pkg::CH_G: begin
          for (int g = 0; g < 4; g++) begin
            if (ev_i.acc == glp_pkg::VW'(g) * glp_pkg::SCALE && (g == 0 || !ev_i.neg)) begin
              modal_n = 2'(g);
              kind_n = 3'(g);
            end
          end
        end
        glp_pkg::CH_X: begin ax_n[0] = v; flg_n[0] = 1'b1; end
        glp_pkg::CH_Y: begin ax_n[1] = v; flg_n[0] = 1'b1; end
        glp_pkg::CH_Z: begin ax_n[2] = v; flg_n[0] = 1'b1; end
        glp_pkg::CH_I: begin arc_n[0] = v; flg_n[1] = 1'b1; end
        glp_pkg::CH_J: begin arc_n[1] = v; flg_n[1] = 1'b1; end
        glp_pkg::CH_K: begin arc_n[2] = v; flg_n[1] = 1'b1; end
        glp_pkg::CH_F: begin feed_n = v; flg_n[3] = 1'b1; end
        glp_pkg::CH_T: begin
          tool_n = ev_i.neg ? 16'd0 - ev_i.whole
                 : ((ev_i.whole > glp_pkg::TOOL_POS_MAX) ? glp_pkg::TOOL_POS_MAX : ev_i.whole);
          kind_n = glp_pkg::MK_TOOL;
          flg_n[2] = 1'b1;
        end
        glp_pkg::CH_M: begin
          if (ev_i.acc == glp_pkg::M_TOOL_CHANGE * glp_pkg::SCALE && !ev_i.neg) begin
            kind_n = glp_pkg::MK_TOOL;
            flg_n[2] = 1'b1;
          end
        end
        default: ;
      endcase
    end
    fire = ev_i.lend && ev_i.allow && (flg_n != '0);
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && fire) begin
      od_q.motion_kind <= kind_n;
      od_q.pos_x <= ax_n[0];
      od_q.pos_y <= ax_n[1];
      od_q.pos_z <= ax_n[2];
      od_q.center_i <= arc_n[0];
      od_q.center_j <= arc_n[1];
      od_q.center_k <= arc_n[2];
      od_q.feed_value <= feed_n;
      od_q.tool_number <= tool_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modal_q <= '0;
      kind_q <= glp_pkg::MK_RAPID;
      ax_q <= '{default: '0};
      arc_q <= '{default: '0};
      feed_q <= '0;
      tool_q <= '0;
      flg_q <= '0;
      ov_q <= 1'b0;
    end else begin
      if (pop_o) begin
        modal_q <= modal_n;
        ax_q <= ax_n;
        feed_q <= feed_n;
        tool_q <= tool_n;
        if (ev_i.lend) begin
          arc_q <= '{default: '0};
          flg_q <= '0;
          kind_q <= {1'b0, modal_n};
        end else begin
          arc_q <= arc_n;
          flg_q <= flg_n;
          kind_q <= kind_n;
        end
      end
      if (pop_o && fire) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o = od_q;
endmodule
`default_nettype wire

// ===== sim/gcode_line_parser_tb.sv =====
// testbench for gcode_line_parser: directed and random g-code text, checked
// against a cycle-free line predictor; depends on glp_pkg and the design files
`timescale 1ns / 100ps
module gcode_line_parser_tb;
  import glp_pkg::*;

  localparam longint unsigned MAG_CAP = 64'd1 << 31;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready_o;
  in_t in_data = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  out_t out_data_o;

  gcode_line_parser i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o(out_data_o)
  );

  always #5 clk_i = ~clk_i;

  in_t text_q[$];
  out_t cmd_q[$];
  int unsigned n_in = 0;
  int unsigned n_cmd = 0;
  int unsigned n_lines = 0;
  int unsigned n_bad = 0;

  // predictor state
  line_phase_e lp = PH_START;
  tok_phase_e tk = TK_NONE;
  bit cmt, neg, dig;
  logic [7:0] letter;
  longint unsigned acc;
  int unsigned fc;
  logic [1:0] modal;
  logic [2:0] kind;
  logic [31:0] ax[3];
  logic [31:0] arc[3];
  logic [31:0] feed;
  logic [15:0] tool;
  logic [3:0] seen;

  function automatic longint unsigned p10(int unsigned n);
    longint unsigned r;
    r = 1;
    for (int k = 0; k < n; k++) r = r * 10;
    return r;
  endfunction

  function automatic bit acc_is(longint unsigned k);
    return (acc == k * p10(FRAC_DIGITS)) && (k == 0 || !neg);
  endfunction

  function automatic void close_word();
    logic [31:0] v;
    longint unsigned whole;
    tk = TK_NONE;
    if (!dig) return;
    v = neg ? 32'(64'd0 - acc) : 32'((acc > MAG_CAP - 1) ? MAG_CAP - 1 : acc);
    case (letter)
      CH_G: begin
        for (int g = 0; g < 4; g++)
          if (acc_is(g)) begin
            modal = 2'(g);
            kind = 3'(g);
          end
      end
      CH_X: begin ax[0] = v; seen[0] = 1'b1; end
      CH_Y: begin ax[1] = v; seen[0] = 1'b1; end
      CH_Z: begin ax[2] = v; seen[0] = 1'b1; end
      CH_I: begin arc[0] = v; seen[1] = 1'b1; end
      CH_J: begin arc[1] = v; seen[1] = 1'b1; end
      CH_K: begin arc[2] = v; seen[1] = 1'b1; end
      CH_F: begin feed = v; seen[3] = 1'b1; end
      CH_T: begin
        whole = acc / p10(FRAC_DIGITS);
        if (neg) begin
          if (whole > 32768) whole = 32768;
          tool = 16'(64'd0 - whole);
        end else begin
          if (whole > 32767) whole = 32767;
          tool = 16'(whole);
        end
        kind = MK_TOOL;
        seen[2] = 1'b1;
      end
      CH_M: begin
        if (acc_is(6)) begin
          kind = MK_TOOL;
          seen[2] = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void shift_digit(int unsigned d);
    longint unsigned t;
    dig = 1'b1;
    if (tk == TK_INT) begin
      if (acc > MAG_CAP / 10) begin
        acc = MAG_CAP;
        return;
      end
      t = acc * 10 + d * p10(FRAC_DIGITS);
    end else begin
      if (fc >= FRAC_DIGITS) return;
      t = acc + d * p10(FRAC_DIGITS - 1 - fc);
      fc++;
    end
    acc = (t > MAG_CAP) ? MAG_CAP : t;
  endfunction

  function automatic void scan_char(logic [7:0] c);
    bit isd;
    isd = (c >= "0" && c <= "9");
    if (c == CH_SPACE || (c >= 9 && c <= 13)) begin
      if (tk != TK_NONE) close_word();
      return;
    end
    case (tk)
      TK_NONE: begin
        letter = (c >= "a" && c <= "z") ? c - 8'd32 : c;
        neg = 0;
        acc = 0;
        fc = 0;
        dig = 0;
        tk = TK_LETTER;
      end
      TK_LETTER, TK_SIGN, TK_INT: begin
        if (tk == TK_LETTER && (c == CH_PLUS || c == CH_MINUS)) begin
          neg = (c == CH_MINUS);
          tk = TK_SIGN;
        end else if (isd) begin
          tk = TK_INT;
          shift_digit(c - "0");
        end else if (c == CH_DOT) begin
          tk = TK_FRAC;
        end else begin
          tk = TK_TAIL;
        end
      end
      TK_FRAC: begin
        if (isd) shift_digit(c - "0");
        else tk = TK_TAIL;
      end
      default: ;
    endcase
  endfunction

  function automatic void parse_beat(in_t b);
    out_t o;
    if (b.text_byte != CH_LF) begin
      if (lp == PH_START) lp = (b.text_byte == CH_SLASH) ? PH_SKIP : PH_TEXT;
      if (lp == PH_TEXT) begin
        if (b.text_byte == CH_SEMI) begin
          if (tk != TK_NONE) close_word();
          cmt = 0;
          lp = PH_SEMI;
        end else if (b.text_byte == CH_LPAR) begin
          cmt = 1;
        end else if (b.text_byte == CH_RPAR) begin
          cmt = 0;
        end else if (!cmt) begin
          scan_char(b.text_byte);
        end
      end
    end
    if (b.text_byte == CH_LF || b.text_end) begin
      if (lp == PH_SEMI) lp = PH_TEXT;
      if (lp == PH_TEXT && tk != TK_NONE) close_word();
      if (lp == PH_TEXT && seen != 0) begin
        o.motion_kind = kind;
        o.pos_x = ax[0];
        o.pos_y = ax[1];
        o.pos_z = ax[2];
        o.center_i = arc[0];
        o.center_j = arc[1];
        o.center_k = arc[2];
        o.feed_value = feed;
        o.tool_number = tool;
        cmd_q.push_back(o);
      end
      lp = PH_START;
      cmt = 0;
      tk = TK_NONE;
      arc[0] = 0;
      arc[1] = 0;
      arc[2] = 0;
      seen = 0;
      kind = 3'(modal);
    end
  endfunction

  initial begin
    cmt = 0; neg = 0; dig = 0; letter = 0; acc = 0; fc = 0;
    modal = 0; kind = MK_RAPID; feed = 0; tool = 0; seen = 0;
    for (int k = 0; k < 3; k++) begin
      ax[k] = 0;
      arc[k] = 0;
    end
  end

  // sender
  int unsigned gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
      gap <= 0;
    end else begin
      if (in_valid && in_ready_o) begin
        parse_beat(in_data);
        n_in <= n_in + 1;
      end
      if (!in_valid || in_ready_o) begin
        if (gap > 0) begin
          gap <= gap - 1;
          in_valid <= 1'b0;
        end else if (text_q.size() > 0) begin
          in_data <= text_q.pop_front();
          in_valid <= 1'b1;
          if (text_q.size() > 150 && $urandom_range(0, 15) == 0) gap <= $urandom_range(1, 13);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  int unsigned rgap = 0;
  int unsigned hold = 0;
  bit held = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      rgap <= 0;
      hold <= 0;
      held <= 0;
    end else begin
      if (out_valid_o && out_ready) begin
        n_cmd <= n_cmd + 1;
        if (cmd_q.size() == 0) begin
          n_bad <= n_bad + 1;
          if (n_bad < 10) $display("unexpected command %h", out_data_o);
        end else begin
          out_t e;
          e = cmd_q.pop_front();
          if (out_data_o.motion_kind !== e.motion_kind || out_data_o.pos_x !== e.pos_x ||
              out_data_o.pos_y !== e.pos_y || out_data_o.pos_z !== e.pos_z ||
              out_data_o.center_i !== e.center_i || out_data_o.center_j !== e.center_j ||
              out_data_o.center_k !== e.center_k || out_data_o.feed_value !== e.feed_value ||
              out_data_o.tool_number !== e.tool_number) begin
            n_bad <= n_bad + 1;
            if (n_bad < 10) begin
              $display("cmd %0d exp kind %0d x %0d y %0d z %0d i %0d j %0d k %0d f %0d t %0d",
                       n_cmd, e.motion_kind, e.pos_x, e.pos_y, e.pos_z, e.center_i,
                       e.center_j, e.center_k, e.feed_value, e.tool_number);
              $display("cmd %0d got kind %0d x %0d y %0d z %0d i %0d j %0d k %0d f %0d t %0d",
                       n_cmd, out_data_o.motion_kind, out_data_o.pos_x, out_data_o.pos_y,
                       out_data_o.pos_z, out_data_o.center_i, out_data_o.center_j,
                       out_data_o.center_k, out_data_o.feed_value, out_data_o.tool_number);
            end
          end
        end
      end
      if (!held && n_in >= 400) begin
        held <= 1;
        hold <= 300;
      end else if (hold > 0) begin
        hold <= hold - 1;
      end
      if (rgap > 0) rgap <= rgap - 1;
      else if (text_q.size() > 150 && $urandom_range(0, 15) == 0) rgap <= $urandom_range(1, 13);
      out_ready <= (hold == 0) && (rgap == 0);
    end
  end

  task automatic put_byte(logic [7:0] c, bit e = 0);
    in_t b;
    b.text_byte = c;
    b.text_end = e;
    text_q.push_back(b);
  endtask

  task automatic put_line(string s, bit end_last = 0);
    for (int k = 0; k < s.len(); k++) put_byte(s[k], end_last && k == s.len() - 1);
    if (!end_last) put_byte(CH_LF);
    n_lines++;
  endtask

  function automatic string rand_digits(int unsigned n);
    string s;
    s = "";
    for (int k = 0; k < n; k++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
    return s;
  endfunction

  task automatic put_random_line();
    string letters;
    string s;
    int unsigned nt;
    letters = "GGGXYZIJKFTMxyzgfmtQ";
    s = "";
    if ($urandom_range(0, 15) == 0) s = "/";
    nt = $urandom_range(0, 5);
    for (int t = 0; t < nt; t++) begin
      s = {s, string'(letters[$urandom_range(0, letters.len() - 1)])};
      case ($urandom_range(0, 5))
        0: s = {s, "-"};
        1: s = {s, "+"};
        default: ;
      endcase
      s = {s, rand_digits($urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : $urandom_range(0, 2))};
      if ($urandom_range(0, 2) == 0) s = {s, ".", rand_digits($urandom_range(0, 7))};
      case ($urandom_range(0, 11))
        0: s = {s, "(note)"};
        1: s = {s, ";", rand_digits(2)};
        2: s = {s, "-3"};
        3: s = {s, "(x", rand_digits(1)};
        4: s = {s, ")"};
        default: ;
      endcase
      case ($urandom_range(0, 5))
        0: s = {s, "\t"};
        1: s = {s, string'(8'd13)};
        2: s = {s, string'(8'd11)};
        3: s = {s, string'(8'd12)};
        default: s = {s, " "};
      endcase
    end
    for (int k = 0; k < s.len(); k++) begin
      if ($urandom_range(0, 40) == 0) put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 30) == 0);
      put_byte(s[k]);
    end
    case ($urandom_range(0, 7))
      0: put_byte(CH_LF, 1'b1);
      1: put_byte("X", 1'b1);
      default: put_byte(CH_LF);
    endcase
    n_lines++;
  endtask

  task automatic drain();
    while (text_q.size() > 0 || in_valid || cmd_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    put_line("G1 X1.5 Y-2.25 Z+3");
    put_line("g2 i0.5 j-0.5 k1 f1200");
    put_line("G3 X99999999 Y-99999999 Z0.123456");
    put_line("/X5 Y5");
    put_line("X1 (comment) Y2");
    put_line("X(c)12 Y)7");
    put_line("X3 ;Y4");
    put_line("X9 (a;b");
    put_line("G7 G-0 X1");
    put_line("G3.0 G2.5 M6");
    put_line("M5 X2");
    put_line("T12.7");
    put_line("t-99999 M06");
    put_line("Q5 X1 F");
    put_line("X1-5 Y.5e3 Z-.");
    put_line("");
    put_line("X7", 1'b1);
    put_byte("Y");
    put_byte("8");
    put_byte(CH_LF, 1'b1);
    put_byte(CH_LF);
    put_line({"X-2147483648 ", string'(8'hff), string'(8'h80)});
    drain();
    while (n_lines < 50) put_random_line();
    drain();
    while (n_lines < 80) put_random_line();
    drain();
    $display("%0d text beats in %0d lines gave %0d commands, incl. stalls and comment cases",
             n_in, n_lines, n_cmd);
    if (n_bad == 0 && cmd_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d commands missing", n_bad, cmd_q.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+design
design/glp_pkg.sv
design/glp_front.sv
design/glp_fifo.sv
design/glp_back.sv
design/gcode_line_parser.sv
sim/gcode_line_parser_tb.sv
